FILE: hw/rtl/text_encoding_sniffer_defines.svh
// ----------------------------------------------------------------------------
// text_encoding_sniffer_defines
// assertion macros shared by the encoding sniffer modules
// ----------------------------------------------------------------------------
`ifndef TEXT_ENCODING_SNIFFER_DEFINES_SVH
`define TEXT_ENCODING_SNIFFER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TES_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tes assertion failed");

// next-cycle implication, checked out of reset
`define TES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tes assertion failed");

`endif

FILE: hw/rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// types, codes and helper functions of the text encoding sniffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

    // encoding codes
    localparam logic [1:0] ENC_MBCS = 2'd0;
    localparam logic [1:0] ENC_UTF8 = 2'd1;
    localparam logic [1:0] ENC_LE   = 2'd2;
    localparam logic [1:0] ENC_BE   = 2'd3;

    // byte order marks
    localparam logic [7:0] BOM_U8_B0 = 8'hEF;
    localparam logic [7:0] BOM_U8_B1 = 8'hBB;
    localparam logic [7:0] BOM_U8_B2 = 8'hBF;
    localparam logic [7:0] BOM_FF    = 8'hFF;
    localparam logic [7:0] BOM_FE    = 8'hFE;

    // surrogate ranges
    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;

    // utf-8 lead byte masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] LEAD5_MASK = 8'hFC;
    localparam logic [7:0] LEAD5_PAT  = 8'hF8;
    localparam logic [7:0] LEAD6_MASK = 8'hFE;
    localparam logic [7:0] LEAD6_PAT  = 8'hFC;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [1:0] encoding_code;
        logic       has_bom;
    } result_item_t;

    // one utf-16 byte order validator
    typedef struct packed {
        logic ok;
        logic need;
        logic pair;
    } lane_t;

    typedef struct packed {
        logic [7:0] head0;
        logic [7:0] head1;
        logic [7:0] head2;
        logic [1:0] head_count;
        logic       mbcs_ok;
        logic       u8_ok;
        logic [2:0] u8_tail;
        lane_t      le;
        lane_t      be;
        logic [7:0] held;
        logic       odd;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        head0:      8'h00,
        head1:      8'h00,
        head2:      8'h00,
        head_count: 2'd0,
        mbcs_ok:    1'b1,
        u8_ok:      1'b1,
        u8_tail:    3'd0,
        le:         '{ok: 1'b1, need: 1'b0, pair: 1'b0},
        be:         '{ok: 1'b1, need: 1'b0, pair: 1'b0},
        held:       8'h00,
        odd:        1'b0
    };

    // continuation bytes owed after a lead byte
    function automatic logic [2:0] utf8_owed(input logic [7:0] c);
        logic [2:0] n;
        n = 3'd0;
        if (c[7] == 1'b0)                        n = 3'd0;
        else if ((c & LEAD2_MASK) == LEAD2_PAT)  n = 3'd1;
        else if ((c & LEAD3_MASK) == LEAD3_PAT)  n = 3'd2;
        else if ((c & LEAD4_MASK) == LEAD4_PAT)  n = 3'd3;
        else if ((c & LEAD5_MASK) == LEAD5_PAT)  n = 3'd4;
        else if ((c & LEAD6_MASK) == LEAD6_PAT)  n = 3'd5;
        return n;
    endfunction

    // one 16-bit unit through a utf-16 validator
    function automatic lane_t unit_check(input logic [15:0] u, input lane_t s);
        lane_t r;
        logic  hi;
        logic  lo;
        r  = s;
        hi = (u >= SURR_HI_MIN) && (u <= SURR_HI_MAX);
        lo = (u >= SURR_LO_MIN) && (u <= SURR_LO_MAX);
        if (s.ok) begin
            if (u == 16'h0000) begin
                r.ok = 1'b0;
            end else if (s.need) begin
                if (lo) r.need = 1'b0;
                else    r.ok   = 1'b0;
            end else if (hi) begin
                r.need = 1'b1;
                r.pair = 1'b1;
            end else if (lo) begin
                r.ok = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tes_scan.sv
// ----------------------------------------------------------------------------
// tes_scan
// validator state registers and their per-byte update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_encoding_sniffer_defines.svh"

module tes_scan import tes_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire byte_item_t  item,
    output scan_state_t      post
);

    scan_state_t st_reg;
    scan_state_t st_next;
    logic [7:0]  b;

    assign b = item.data_byte;

    // state after this byte
    always_comb begin
        st_next = st_reg;

        if (st_reg.head_count != 2'd3) begin
            case (st_reg.head_count)
                2'd0:    st_next.head0 = b;
                2'd1:    st_next.head1 = b;
                2'd2:    st_next.head2 = b;
                default: st_next.head2 = st_reg.head2;
            endcase
            st_next.head_count = st_reg.head_count + 2'd1;
        end

        if (b == 8'h00) st_next.mbcs_ok = 1'b0;

        if (st_reg.u8_tail != 3'd0) begin
            if (b[7:6] != 2'b10) st_next.u8_ok = 1'b0;
            st_next.u8_tail = st_reg.u8_tail - 3'd1;
        end else if (b == 8'h00) begin
            st_next.u8_ok = 1'b0;
        end else begin
            st_next.u8_tail = utf8_owed(b);
        end

        if (!st_reg.odd) begin
            st_next.held = b;
            st_next.odd  = 1'b1;
        end else begin
            st_next.odd = 1'b0;
            st_next.le  = unit_check({b, st_reg.held}, st_reg.le);
            st_next.be  = unit_check({st_reg.held, b}, st_reg.be);
        end
    end

    assign post = st_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg <= SCAN_RESET;
        end else if (fire) begin
            st_reg <= item.last_byte ? SCAN_RESET : st_next;
        end
    end

    `TES_ASSERT_NEXT(a_clear_after_last, fire && item.last_byte, st_reg == SCAN_RESET)
    `TES_ASSERT_NOW(a_tail_range, 1'b1, st_reg.u8_tail <= 3'd5)
    `TES_ASSERT_NEXT(a_idle_holds, !fire, $stable(st_reg))

endmodule

`default_nettype wire

FILE: hw/rtl/tes_decide.sv
// ----------------------------------------------------------------------------
// tes_decide
// bom check and tie-break over the validator votes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tes_decide import tes_pkg::*; (
    input  wire scan_state_t s,
    output result_item_t     result
);

    logic       bom_u8;
    logic       bom_le;
    logic       bom_be;
    logic       m;
    logic       u8;
    logic       le;
    logic       be;
    logic [2:0] votes;

    always_comb begin
        bom_u8 = (s.head_count == 2'd3) && (s.head0 == BOM_U8_B0) &&
                 (s.head1 == BOM_U8_B1) && (s.head2 == BOM_U8_B2);
        bom_le = s.head_count[1] && (s.head0 == BOM_FF) && (s.head1 == BOM_FE);
        bom_be = s.head_count[1] && (s.head0 == BOM_FE) && (s.head1 == BOM_FF);

        m  = s.mbcs_ok;
        u8 = s.u8_ok && (s.u8_tail == 3'd0);
        le = s.le.ok && !s.odd && !s.le.need;
        be = s.be.ok && !s.odd && !s.be.need;
        votes = {2'b00, m} + {2'b00, u8} + {2'b00, le} + {2'b00, be};

        result.has_bom       = 1'b0;
        result.encoding_code = ENC_MBCS;
        if (bom_u8) begin
            result.has_bom       = 1'b1;
            result.encoding_code = ENC_UTF8;
        end else if (bom_le) begin
            result.has_bom       = 1'b1;
            result.encoding_code = ENC_LE;
        end else if (bom_be) begin
            result.has_bom       = 1'b1;
            result.encoding_code = ENC_BE;
        end else if (votes == 3'd1) begin
            if (u8)      result.encoding_code = ENC_UTF8;
            else if (le) result.encoding_code = ENC_LE;
            else if (be) result.encoding_code = ENC_BE;
        end else if (votes > 3'd1) begin
            if (le && be && !u8)
                result.encoding_code = (s.be.pair && !s.le.pair) ? ENC_BE : ENC_LE;
            else
                result.encoding_code = ENC_UTF8;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/text_encoding_sniffer.sv
// ----------------------------------------------------------------------------
// text_encoding_sniffer
// guesses the text encoding of a byte buffer streamed one byte per transfer
// ----------------------------------------------------------------------------
// Bytes of a buffer arrive one per transfer on the byte channel, the final
// byte marked by last_byte. For each buffer exactly one result transfer comes
// out: MBCS, UTF-8, UTF-16LE or UTF-16BE plus a BOM flag. The block takes one
// byte every clock while no last byte is held back; the byte sits in the input
// register while the validator update and the tie-break run, and the result is
// loaded into the output register as the last byte moves on. Only a stalled
// result holds back a waiting last byte; ordinary bytes keep flowing. No
// clearing pass after reset is needed, and all validator state clears itself
// after each last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_encoding_sniffer_defines.svh"

module text_encoding_sniffer import tes_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // byte channel
    input  wire logic         byte_valid,
    output logic              byte_stall,
    input  wire byte_item_t   byte_item,
    // result channel
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_item_t      result_item
);

    // input register
    logic         in_valid_reg;
    logic         in_valid_next;
    byte_item_t   in_item_reg;

    // output register
    logic         out_valid_reg;
    logic         out_valid_next;
    result_item_t out_item_reg;

    logic         accept;
    logic         out_free;
    logic         fire;
    logic         out_has_bom;
    scan_state_t  post;
    result_item_t decided;

    // the held byte moves on unless it is a last byte facing a full, stalled output
    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign byte_stall = in_valid_reg && !fire;
    assign accept     = byte_valid && !byte_stall;

    // validators update on every fired byte
    tes_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .post  (post)
    );

    // verdict from the state including the current byte
    tes_decide u_decide (
        .s      (post),
        .result (decided)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept)    in_valid_next = 1'b1;
        else if (fire) in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire && in_item_reg.last_byte) out_valid_next = 1'b1;
        else if (!result_stall)            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk) begin
        if (accept) in_item_reg <= byte_item;
        if (fire && in_item_reg.last_byte) out_item_reg <= decided;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;
    assign out_has_bom  = out_valid_reg && out_item_reg.has_bom;

    // a result only ever comes from a last byte that fired
    `TES_ASSERT_NOW(a_result_from_last, $rose(out_valid_reg), $past(fire && in_item_reg.last_byte))
    // a held byte that did not move on is still there
    `TES_ASSERT_NEXT(a_stage_holds, in_valid_reg && !fire, in_valid_reg)
    // a bom always names a unicode encoding
    `TES_ASSERT_NOW(a_bom_not_mbcs, out_has_bom, out_item_reg.encoding_code != ENC_MBCS)

endmodule

`default_nettype wire
